// ===== rtl/core/mid_pkg.sv =====
// ----------------------------------------------------------------------------
// mid_pkg
// Shared types and constants of the multi-image difference marker.
// ----------------------------------------------------------------------------
`default_nettype none

package mid_pkg;

  // Channel layout of an ARGB32 pixel, index 0 is blue and 3 is alpha.
  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_W       = 8;
  localparam int PIXEL_W      = NUM_CHANNELS * CHAN_W;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef chan_t [NUM_CHANNELS-1:0] chan_vec_t;
  typedef logic [PIXEL_W-1:0] pixel_t;

  // Result colors.
  localparam pixel_t COLOR_NONE  = 32'h00FF_FFFF;
  localparam pixel_t COLOR_MAJOR = 32'hFFFF_0000;
  localparam pixel_t COLOR_MINOR = 32'hFF00_00FF;

  // Difference classes.
  typedef logic [1:0] diff_class_t;
  localparam diff_class_t CLASS_NONE  = 2'd0;
  localparam diff_class_t CLASS_MINOR = 2'd1;
  localparam diff_class_t CLASS_MAJOR = 2'd2;

  // Channel bounds at the opening of a position.
  localparam chan_t CHAN_LOW_INIT  = 8'hFF;
  localparam chan_t CHAN_HIGH_INIT = 8'h00;

  // Configuration register map, selected by paddr[2].
  localparam int  APB_ADDR_W     = 3;
  localparam int  APB_DATA_W     = 32;
  localparam logic REG_TOLERANCE  = 1'b0;
  localparam logic REG_SHOW_MINOR = 1'b1;

  // Configuration as seen by the datapath.
  typedef struct packed {
    chan_t tolerance;
    logic  show_minor;
  } cfg_t;

  // Per-position summary handed from accumulation to classification.
  typedef struct packed {
    chan_vec_t low;
    chan_vec_t high;
    logic      absent;
  } summary_t;

endpackage

`default_nettype wire

// ===== rtl/core/mid_if.sv =====
// ----------------------------------------------------------------------------
// mid_sample_if / mid_result_if
// Valid/ready channels for input samples and result colors.
// ----------------------------------------------------------------------------
`default_nettype none

interface mid_sample_if
  import mid_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t pixel_argb;
  logic   present;
  logic   last_sample;

  modport source (output valid, pixel_argb, present, last_sample, input ready);
  modport sink   (input valid, pixel_argb, present, last_sample, output ready);
endinterface

interface mid_result_if
  import mid_pkg::*;
  ();
  logic        valid;
  logic        ready;
  pixel_t      out_color;
  diff_class_t diff_class;
  chan_t       max_difference;

  modport source (output valid, out_color, diff_class, max_difference, input ready);
  modport sink   (input valid, out_color, diff_class, max_difference, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mid_cfg.sv =====
// ----------------------------------------------------------------------------
// mid_cfg
// APB register file holding the tolerance and the minor-marking enable.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_cfg
  import mid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes; bits above each register's width are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance  <= '0;
      cfg.show_minor <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TOLERANCE:  cfg.tolerance  <= pwdata[CHAN_W-1:0];
        REG_SHOW_MINOR: cfg.show_minor <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_TOLERANCE:  prdata[CHAN_W-1:0] = cfg.tolerance;
      REG_SHOW_MINOR: prdata[0]          = cfg.show_minor;
      default: ;
    endcase
  end

  // Low address bits need no decode.
  logic unused_addr;
  assign unused_addr = ^paddr[1:0];

endmodule

`default_nettype wire

// ===== rtl/core/mid_accum.sv =====
// ----------------------------------------------------------------------------
// mid_accum
// Sample register and running per-channel min/max of one raster position.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_accum
  import mid_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  mid_sample_if.sink sample,
  output logic       sum_valid,
  input  wire logic  sum_ready,
  output summary_t   sum_data
);

  // Sample register.
  logic   smp_valid;
  pixel_t smp_pixel;
  logic   smp_present;
  logic   smp_last;
  logic   smp_take;

  // Position state.
  chan_vec_t chan_low;
  chan_vec_t chan_high;
  logic      absent_seen;
  logic      first_of_position;

  chan_vec_t chan_low_next;
  chan_vec_t chan_high_next;
  logic      absent_seen_next;

  // A non-last sample only updates state; a last one also needs the summary slot.
  assign smp_take     = smp_valid & (~smp_last | ~sum_valid | sum_ready);
  assign sample.ready = ~smp_valid | smp_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample.ready) begin
      smp_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      smp_pixel   <= sample.pixel_argb;
      smp_present <= sample.present;
      smp_last    <= sample.last_sample;
    end
  end

  // Min/max update, starting from fresh bounds on the first sample of a position.
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_low_next[c]  = first_of_position ? CHAN_LOW_INIT  : chan_low[c];
      chan_high_next[c] = first_of_position ? CHAN_HIGH_INIT : chan_high[c];
      if (smp_present) begin
        if (smp_pixel[CHAN_W*c +: CHAN_W] < chan_low_next[c]) begin
          chan_low_next[c] = smp_pixel[CHAN_W*c +: CHAN_W];
        end
        if (smp_pixel[CHAN_W*c +: CHAN_W] > chan_high_next[c]) begin
          chan_high_next[c] = smp_pixel[CHAN_W*c +: CHAN_W];
        end
      end
    end
    absent_seen_next = (first_of_position ? 1'b0 : absent_seen) | ~smp_present;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      absent_seen       <= 1'b0;
      first_of_position <= 1'b1;
    end else if (smp_take) begin
      absent_seen       <= absent_seen_next;
      first_of_position <= smp_last;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_take) begin
      chan_low  <= chan_low_next;
      chan_high <= chan_high_next;
    end
  end

  // Summary register, loaded when a position closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (smp_take && smp_last) begin
      sum_valid <= 1'b1;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_take && smp_last) begin
      sum_data.low    <= chan_low_next;
      sum_data.high   <= chan_high_next;
      sum_data.absent <= absent_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mid_classify.sv =====
// ----------------------------------------------------------------------------
// mid_classify
// Largest channel spread, difference class and result color register.
// ----------------------------------------------------------------------------
`default_nettype none

module mid_classify
  import mid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sum_valid,
  output logic         sum_ready,
  input  wire summary_t sum_data,
  input  wire cfg_t    cfg,
  mid_result_if.source result
);

  chan_t       spread;
  chan_t       chan_diff;
  pixel_t      color_next;
  diff_class_t class_next;

  assign sum_ready = ~result.valid | result.ready;

  // Largest high-minus-low over the channels; empty bounds give zero.
  always_comb begin
    spread    = '0;
    chan_diff = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_diff = (sum_data.high[c] > sum_data.low[c]) ?
                  chan_t'(sum_data.high[c] - sum_data.low[c]) : '0;
      if (chan_diff > spread) begin
        spread = chan_diff;
      end
    end
  end

  // Classification: missing or out of tolerance wins over minor marking.
  always_comb begin
    priority if (sum_data.absent || (spread > cfg.tolerance)) begin
      color_next = COLOR_MAJOR;
      class_next = CLASS_MAJOR;
    end else if (cfg.show_minor && (spread != '0)) begin
      color_next = COLOR_MINOR;
      class_next = CLASS_MINOR;
    end else begin
      color_next = COLOR_NONE;
      class_next = CLASS_NONE;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (sum_ready) begin
      result.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      result.out_color      <= color_next;
      result.diff_class     <= class_next;
      result.max_difference <= spread;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multi_image_difference_marker.sv =====
// ----------------------------------------------------------------------------
// multi_image_difference_marker
// Marks how much the images covering one raster position differ.
// ----------------------------------------------------------------------------
// The block takes one ARGB32 sample per image per position and one sample
// every clock cycle while it is not stalled, with no gaps between positions.
// Each position ends with a sample flagged last_sample and then yields one
// result; other samples yield none. A result passes through the sample
// register and the per-position summary register into the result register,
// where it is held until it is transferred. Both channels stall freely; a
// held result does not stop samples of the next position before its last one.
// Configuration registers are to be written over APB only while the block is
// idle, by the user; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_image_difference_marker
  import mid_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  mid_sample_if.sink                 sample,
  mid_result_if.source               result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t     cfg;
  logic     sum_valid;
  logic     sum_ready;
  summary_t sum_data;

  // Configuration registers.
  mid_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-position min/max accumulation.
  mid_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  // Spread and color classification.
  mid_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .cfg       (cfg),
    .result    (result)
  );

endmodule

`default_nettype wire
